[rtl/core/base64_stream_decoder_unit_defines.svh]
// Assertion macros for the base64 stream decoder.
// Included by the top level; relies on a clock named clk and a reset named rst.
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64D_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/b64d_pkg.sv]
// Shared types, codes and character tables for the base64 stream decoder.
// No dependencies.
package b64d_pkg;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_DONE = 2'd1;
  localparam logic [1:0] PAD_HALF = 2'd2;

  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // Result queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       end_of_text;
  } char_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_of_run;
  } res_item_t;

  typedef struct packed {
    logic [1:0] quartet_pos;
    logic [5:0] prev_sextet;
    logic [1:0] pad_state;
    logic       failed;
  } dec_state_t;

  typedef struct packed {
    logic [Q_CW-1:0] fill;
    logic            room;
  } q_status_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Bit 6 set means the octet is not in the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      return {1'b0, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      return {1'b0, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      return {1'b0, d[5:0]};
    end else if (c == 8'h2B) begin
      return 7'd62;
    end else if (c == 8'h2F) begin
      return 7'd63;
    end
    return 7'h40;
  endfunction

endpackage

[rtl/core/b64d_step.sv]
// Per-character decode step: next state and up to two results for one item.
// Depends on b64d_pkg.
module b64d_step import b64d_pkg::*; (
  input  char_item_t item,
  input  dec_state_t st,
  output dec_state_t st_next,
  output res_item_t  res0,
  output res_item_t  res1,
  output logic [1:0] res_count
);

  logic [6:0] sx;
  logic       emit;
  logic [7:0] byte_val;
  logic       bad_end;
  dec_state_t s;
  res_item_t  status;

  assign sx = sextet_of(item.ch);

  always_comb begin
    s        = st;
    emit     = 1'b0;
    byte_val = 8'h00;
    if (item.has_char && !st.failed) begin
      if (st.pad_state == PAD_DONE) begin
        s.failed = 1'b1;
      end else if (st.pad_state == PAD_HALF) begin
        if (item.ch == CHAR_PAD) s.pad_state = PAD_DONE;
        else s.failed = 1'b1;
      end else if (is_space(item.ch)) begin
        s = st;
      end else if (!sx[6]) begin
        unique case (st.quartet_pos)
          2'd1: byte_val = {st.prev_sextet, sx[5:4]};
          2'd2: byte_val = {st.prev_sextet[3:0], sx[5:2]};
          2'd3: byte_val = {st.prev_sextet[1:0], sx[5:0]};
          default: byte_val = 8'h00;
        endcase
        emit          = (st.quartet_pos != 2'd0);
        s.prev_sextet = sx[5:0];
        s.quartet_pos = st.quartet_pos + 2'd1;
      end else if (item.ch == CHAR_PAD && st.quartet_pos == 2'd3) begin
        s.pad_state   = PAD_DONE;
        s.quartet_pos = 2'd0;
      end else if (item.ch == CHAR_PAD && st.quartet_pos == 2'd2) begin
        s.pad_state   = PAD_HALF;
        s.quartet_pos = 2'd0;
      end else begin
        s.failed = 1'b1;
      end
    end
  end

  // The end item closes the message and returns to the reset state.
  assign bad_end = s.failed || (s.quartet_pos != 2'd0) || (s.pad_state == PAD_HALF);

  always_comb begin
    status.kind        = bad_end ? KIND_BAD : KIND_OK;
    status.data_byte   = 8'h00;
    status.last_of_run = 1'b1;
  end

  always_comb begin
    st_next = item.end_of_text ? '0 : s;
    res0.kind        = KIND_DATA;
    res0.data_byte   = byte_val;
    res0.last_of_run = !item.end_of_text;
    res1             = status;
    res_count        = {1'b0, emit} + {1'b0, item.end_of_text};
    if (!emit) res0 = status;
  end

endmodule

[rtl/core/b64d_fifo.sv]
// Small result queue: up to two writes and one read per cycle.
// Depends on b64d_pkg.
module b64d_fifo import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  res_item_t  wr0,
  input  res_item_t  wr1,
  input  logic       pop,
  output logic       head_valid,
  output res_item_t  head,
  output q_status_t  stat
);

  res_item_t       entries [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_CW-1:0] fill;
  logic [Q_CW-1:0] fill_next;
  logic            do_pop;

  assign head_valid = (fill != '0);
  assign head       = entries[rptr];
  assign do_pop     = pop && head_valid;
  assign fill_next  = fill + Q_CW'(push_count) - Q_CW'(do_pop);

  // Room for the worst case of two results, whatever is read this cycle.
  assign stat.fill = fill;
  assign stat.room = (fill <= Q_CW'(Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      wptr <= wptr + Q_AW'(push_count);
      if (do_pop) rptr <= rptr + Q_AW'(1);
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wptr] <= wr0;
    if (push_count == 2'd2) entries[wptr + Q_AW'(1)] <= wr1;
  end

endmodule

[rtl/core/base64_stream_decoder_unit.sv]
// Top level of the streaming base64 decoder.
// Depends on b64d_pkg, b64d_step, b64d_fifo and the assertion macro header.

// One character item is taken every cycle into an input register unless char_stall is
// high, decoded there and its results (none, one or two) written to a four-entry result
// queue once the queue has room for two; the first result is offered from the queue
// after the write. Results leave one per cycle while res_stall is low, so the sustained
// rate is one item per cycle as long as the items average at most one result each; an
// item that ends a message with a data byte gives two results. Data bytes stream out as
// soon as each character completes them, and the single status result on the end item
// says whether the message was valid; on an error status, discard the bytes of that
// message.
`include "base64_stream_decoder_unit_defines.svh"

module base64_stream_decoder_unit import b64d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_item_t char_item,
  output logic       res_valid,
  input  logic       res_stall,
  output res_item_t  res_item
);

  logic       hold_valid;
  char_item_t hold_item;
  dec_state_t st;
  dec_state_t st_next;
  res_item_t  res0;
  res_item_t  res1;
  logic [1:0] step_count;
  logic [1:0] push_count;
  q_status_t  q_stat;
  logic       take;

  assign take       = hold_valid && q_stat.room;
  assign char_stall = hold_valid && !q_stat.room;
  assign push_count = take ? step_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (char_valid && !char_stall) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) hold_item <= char_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  b64d_step u_step (
    .item      (hold_item),
    .st        (st),
    .st_next   (st_next),
    .res0      (res0),
    .res1      (res1),
    .res_count (step_count)
  );

  b64d_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .wr0        (res0),
    .wr1        (res1),
    .pop        (!res_stall),
    .head_valid (res_valid),
    .head       (res_item),
    .stat       (q_stat)
  );

  `B64D_ASSERT_SAME(a_fill_bound, 1'b1, q_stat.fill <= Q_CW'(Q_DEPTH), "result queue overfilled")
  `B64D_ASSERT_NEXT(a_end_resets, take && hold_item.end_of_text, st == '0, "state not cleared after end item")
  `B64D_ASSERT_SAME(a_end_reports, take && hold_item.end_of_text, step_count != 2'd0, "end item gave no status")
  `B64D_ASSERT_NEXT(a_fail_sticks, take && st.failed && !hold_item.end_of_text, st.failed, "error flag dropped within a message")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the streaming base64 decoder (base64_stream_decoder_unit).
// Depends on b64d_pkg for the item types, result kinds, padding states and the pad octet.
`timescale 1ns / 1ps

module testbench;
  import b64d_pkg::*;

  typedef enum int {
    FAULT_NONE,
    FAULT_SWAP,
    FAULT_DROP,
    FAULT_TAIL,
    FAULT_STRAY_PAD,
    FAULT_NOISE
  } fault_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  char_item_t char_item = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  res_item_t  res_item;

  string alphabet_chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  char_item_t char_backlog[$];
  res_item_t  predicted_decodes[$];
  res_item_t  oldest_decode;
  int         items_pushed = 0;
  int         items_taken = 0;
  int         stim_items = 0;
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  // Decoder state as the testbench sees it.
  logic [1:0] dq_pos = 2'd0;
  logic [5:0] dq_prev = 6'd0;
  logic [1:0] dq_pad = PAD_NONE;
  logic       dq_failed = 1'b0;

  base64_stream_decoder_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Returns -1 for an octet outside the alphabet.
  function automatic int sextet_value(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (alphabet_chars[i] == c) return i;
    end
    return -1;
  endfunction

  task automatic predict_decode(input char_item_t it);
    int         sx;
    logic [7:0] b;
    bit         emit;
    emit = 1'b0;
    b = 8'h00;
    if (it.has_char && !dq_failed) begin
      if (dq_pad == PAD_DONE) begin
        dq_failed = 1'b1;
      end else if (dq_pad == PAD_HALF) begin
        if (it.ch == CHAR_PAD) dq_pad = PAD_DONE;
        else dq_failed = 1'b1;
      end else if (!is_blank(it.ch)) begin
        sx = sextet_value(it.ch);
        if (sx >= 0) begin
          case (dq_pos)
            2'd1: b = {dq_prev, sx[5:4]};
            2'd2: b = {dq_prev[3:0], sx[5:2]};
            2'd3: b = {dq_prev[1:0], sx[5:0]};
            default: ;
          endcase
          emit = (dq_pos != 2'd0);
          dq_prev = sx[5:0];
          dq_pos = dq_pos + 2'd1;
        end else if (it.ch == CHAR_PAD && dq_pos == 2'd3) begin
          dq_pad = PAD_DONE;
          dq_pos = 2'd0;
        end else if (it.ch == CHAR_PAD && dq_pos == 2'd2) begin
          dq_pad = PAD_HALF;
          dq_pos = 2'd0;
        end else begin
          dq_failed = 1'b1;
        end
      end
    end
    if (emit) begin
      predicted_decodes.push_back('{kind: KIND_DATA, data_byte: b,
                                    last_of_run: !it.end_of_text});
    end
    if (it.end_of_text) begin
      if (dq_pos != 2'd0 || dq_pad == PAD_HALF) dq_failed = 1'b1;
      predicted_decodes.push_back('{kind: dq_failed ? KIND_BAD : KIND_OK,
                                    data_byte: 8'h00, last_of_run: 1'b1});
      dq_pos = 2'd0;
      dq_prev = 6'd0;
      dq_pad = PAD_NONE;
      dq_failed = 1'b0;
    end
  endtask

  // Driver: a new item is offered only once the current one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        predict_decode(char_item);
        items_taken++;
      end
      if (!char_valid || !char_stall) begin
        if (char_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          char_valid <= 1'b1;
          char_item <= char_backlog.pop_front();
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (predicted_decodes.size() == 0) begin
          $error("unexpected result: kind %0d, data_byte %02h", res_item.kind,
                 res_item.data_byte);
          mismatch_count++;
        end else begin
          oldest_decode = predicted_decodes.pop_front();
          if (res_item.kind !== oldest_decode.kind) begin
            $error("kind: expected %0d, actual %0d", oldest_decode.kind, res_item.kind);
            mismatch_count++;
          end
          if (res_item.data_byte !== oldest_decode.data_byte) begin
            $error("data_byte: expected %02h, actual %02h", oldest_decode.data_byte,
                   res_item.data_byte);
            mismatch_count++;
          end
          if (res_item.last_of_run !== oldest_decode.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", oldest_decode.last_of_run,
                   res_item.last_of_run);
            mismatch_count++;
          end
        end
      end
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_item(input logic [7:0] c, input logic has, input logic eot);
    char_backlog.push_back('{ch: c, has_char: has, end_of_text: eot});
    items_pushed++;
    if (has || eot) stim_items++;
  endtask

  // Pushes a string of characters; the last one optionally carries the end mark.
  task automatic push_text(input string s, input bit end_on_last);
    for (int i = 0; i < s.len(); i++) begin
      push_item(s[i], 1'b1, end_on_last && i == s.len() - 1);
    end
  endtask

  task automatic push_blank();
    int k;
    k = $urandom_range(5);
    push_item((k == 5) ? 8'h20 : 8'(9 + k), 1'b1, 1'b0);
  endtask

  // One message: random quartets, optional padding, then an optional fault.
  task automatic add_message(input fault_e fault);
    logic [7:0] txt[$];
    int         nq;
    int         npad;
    bit         merge;
    nq = ($urandom_range(9) == 0) ? $urandom_range(8) : $urandom_range(3);
    npad = $urandom_range(2);
    for (int i = 0; i < nq * 4; i++) txt.push_back(alphabet_chars[$urandom_range(63)]);
    if (npad > 0) begin
      for (int i = 0; i < 4 - npad; i++) txt.push_back(alphabet_chars[$urandom_range(63)]);
      for (int i = 0; i < npad; i++) txt.push_back(CHAR_PAD);
    end
    case (fault)
      FAULT_SWAP: if (txt.size() > 0) txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
      FAULT_DROP: if (txt.size() > 0) txt.delete($urandom_range(txt.size() - 1));
      FAULT_TAIL: txt.push_back(8'($urandom_range(255)));
      FAULT_STRAY_PAD: txt.insert($urandom_range(txt.size()), CHAR_PAD);
      FAULT_NOISE: begin
        txt.delete();
        repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
    merge = txt.size() > 0 && $urandom_range(1) == 1;
    foreach (txt[i]) begin
      if (txt[i] != CHAR_PAD && $urandom_range(15) == 0) push_blank();
      if ($urandom_range(19) == 0) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
      push_item(txt[i], 1'b1, merge && i == txt.size() - 1);
    end
    if (!merge) push_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    while (items_taken != items_pushed) @(posedge clk);
    while (predicted_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic run_phase(input int sidle, input int ridle, input int target);
    int     start;
    fault_e f;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    start = stim_items;
    while (stim_items - start < target) begin
      if ($urandom_range(9) < 7) f = FAULT_NONE;
      else f = fault_e'($urandom_range(FAULT_SWAP, FAULT_NOISE));
      add_message(f);
    end
    drain();
  endtask

  initial begin
    while (rst) @(posedge clk);
    send_idle_pct = 35;
    recv_idle_pct = 50;
    push_item(8'h00, 1'b0, 1'b1);       // empty message ends ok
    push_text("TWFu", 1'b1);            // full quartet, end rides on the last character
    push_text("T\tQ==", 1'b1);          // whitespace inside, double padding
    push_text("TWE=", 1'b1);            // single padding
    push_item(8'hFF, 1'b0, 1'b0);       // idle item, no result
    push_item(8'hFF, 1'b1, 1'b1);       // octet outside the alphabet
    push_text("=", 1'b1);               // padding at the start of a quartet
    push_text("A=", 1'b1);              // padding after one character
    push_text("Zm9=", 1'b0);
    push_item(8'h20, 1'b1, 1'b1);       // whitespace after completed padding
    push_text("AB=A", 1'b1);            // something other than a second pad
    push_text("A", 1'b1);               // message ends inside a quartet
    push_text("AB=", 1'b1);             // message ends after half of a double pad
    run_phase(35, 50, 530);
    run_phase(50, 35, 530);
    run_phase(0, 0, 530);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/b64d_pkg.sv
rtl/core/b64d_step.sv
rtl/core/b64d_fifo.sv
rtl/core/base64_stream_decoder_unit.sv
tb/testbench.sv
